// ===== hdl/dds_pkg.sv =====
// Shared types, register codes and reset values for the drive command shaper.
`default_nettype none

package dds_pkg;

	// Default widths handed to the top level parameters
	localparam int VELOCITY_BITS_DEF     = 16;
	localparam int TICK_COUNTER_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;

	// Register reset values
	localparam logic [63:0] LINEAR_LIMITS_RST   = 64'd0;
	localparam logic [63:0] ANGULAR_LIMITS_RST  = 64'd0;
	localparam logic [4:0]  MODE_FLAGS_RST      = 5'd1;
	localparam logic [15:0] HALF_SEPARATION_RST = 16'd8192;
	localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd50;
	localparam logic [15:0] DUTY_GAIN_RST       = 16'd25600;
	localparam logic [23:0] COUNT_GAIN_RST      = 24'd2607590;
	localparam logic [14:0] MAX_DUTY_RST        = 15'd15360;

	// Mode flag bit positions
	localparam int MODE_OPEN_LOOP = 0;
	localparam int MODE_LIN_VLIM  = 1;
	localparam int MODE_ANG_VLIM  = 2;
	localparam int MODE_LIN_ACCEL = 3;
	localparam int MODE_ANG_ACCEL = 4;

	// Request kinds on the input stream
	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_LINEAR_LIMITS   = 3'd0,
		CFG_ANGULAR_LIMITS  = 3'd1,
		CFG_MODE_FLAGS      = 3'd2,
		CFG_HALF_SEPARATION = 3'd3,
		CFG_TIMEOUT_TICKS   = 3'd4,
		CFG_DUTY_GAIN       = 3'd5,
		CFG_COUNT_GAIN      = 3'd6,
		CFG_MAX_DUTY        = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [63:0] linear_limits;
		logic [63:0] angular_limits;
		logic [4:0]  mode_flags;
		logic [15:0] half_separation;
		logic [15:0] timeout_ticks;
		logic [15:0] duty_gain;
		logic [23:0] count_gain;
		logic [14:0] max_duty;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHAPE,
		ST_HW_MUL,
		ST_HW_RND,
		ST_L_MUL,
		ST_L_DRV,
		ST_R_MUL,
		ST_R_DRV
	} ctrl_state_t;

	typedef enum logic [1:0] {
		MUL_HW,
		MUL_LEFT,
		MUL_RIGHT
	} mul_sel_t;

	typedef struct packed {
		logic     store_cmd;
		logic     start_tick;
		logic     shape;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     hw_load;
		logic     left_load;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/dds_cfg.sv =====
// Configuration register bank with write-only access.
`default_nettype none

module dds_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 we,
	input  wire logic [dds_pkg::CFG_INDEX_BITS-1:0]   index,
	input  wire logic [dds_pkg::CFG_DATA_BITS-1:0]    data,
	output dds_pkg::cfg_t                             cfg
);

	dds_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.linear_limits   <= dds_pkg::LINEAR_LIMITS_RST;
			cfg_q.angular_limits  <= dds_pkg::ANGULAR_LIMITS_RST;
			cfg_q.mode_flags      <= dds_pkg::MODE_FLAGS_RST;
			cfg_q.half_separation <= dds_pkg::HALF_SEPARATION_RST;
			cfg_q.timeout_ticks   <= dds_pkg::TIMEOUT_TICKS_RST;
			cfg_q.duty_gain       <= dds_pkg::DUTY_GAIN_RST;
			cfg_q.count_gain      <= dds_pkg::COUNT_GAIN_RST;
			cfg_q.max_duty        <= dds_pkg::MAX_DUTY_RST;
		end else if (we) begin
			case (dds_pkg::cfg_index_t'(index))
				dds_pkg::CFG_LINEAR_LIMITS:   cfg_q.linear_limits   <= data;
				dds_pkg::CFG_ANGULAR_LIMITS:  cfg_q.angular_limits  <= data;
				dds_pkg::CFG_MODE_FLAGS:      cfg_q.mode_flags      <= data[4:0];
				dds_pkg::CFG_HALF_SEPARATION: cfg_q.half_separation <= data[15:0];
				dds_pkg::CFG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= data[15:0];
				dds_pkg::CFG_DUTY_GAIN:       cfg_q.duty_gain       <= data[15:0];
				dds_pkg::CFG_COUNT_GAIN:      cfg_q.count_gain      <= data[23:0];
				dds_pkg::CFG_MAX_DUTY:        cfg_q.max_duty        <= data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/dds_ctrl.sv =====
// Sequencer that steps a control tick through the shared multiplier.
`default_nettype none

module dds_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_op,
	output logic                     in_ready,
	input  wire dds_pkg::dp_status_t status,
	output dds_pkg::dp_cmd_t         cmd
);

	dds_pkg::ctrl_state_t state_q;
	dds_pkg::ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dds_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			dds_pkg::ST_IDLE: begin
				if (in_valid && (in_op == dds_pkg::OP_TICK)) begin
					state_next = dds_pkg::ST_SHAPE;
				end
			end
			dds_pkg::ST_SHAPE:  state_next = dds_pkg::ST_HW_MUL;
			dds_pkg::ST_HW_MUL: state_next = dds_pkg::ST_HW_RND;
			dds_pkg::ST_HW_RND: state_next = dds_pkg::ST_L_MUL;
			dds_pkg::ST_L_MUL:  state_next = dds_pkg::ST_L_DRV;
			dds_pkg::ST_L_DRV:  state_next = dds_pkg::ST_R_MUL;
			dds_pkg::ST_R_MUL:  state_next = dds_pkg::ST_R_DRV;
			dds_pkg::ST_R_DRV: begin
				if (status.out_free) begin
					state_next = dds_pkg::ST_IDLE;
				end
			end
			default: state_next = dds_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.mul_sel = dds_pkg::MUL_HW;
		case (state_q)
			dds_pkg::ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.store_cmd  = in_valid && (in_op == dds_pkg::OP_COMMAND);
				cmd.start_tick = in_valid && (in_op == dds_pkg::OP_TICK);
			end
			dds_pkg::ST_SHAPE: cmd.shape = 1'b1;
			dds_pkg::ST_HW_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = dds_pkg::MUL_HW;
			end
			dds_pkg::ST_HW_RND: cmd.hw_load = 1'b1;
			dds_pkg::ST_L_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = dds_pkg::MUL_LEFT;
			end
			dds_pkg::ST_L_DRV: cmd.left_load = 1'b1;
			dds_pkg::ST_R_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = dds_pkg::MUL_RIGHT;
			end
			dds_pkg::ST_R_DRV: cmd.out_load = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/dds_dp.sv =====
// Datapath: command store, tick shaping, shared multiplier and result register.
`default_nettype none

module dds_dp #(
	parameter int VELOCITY_BITS     = dds_pkg::VELOCITY_BITS_DEF,
	parameter int TICK_COUNTER_BITS = dds_pkg::TICK_COUNTER_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dds_pkg::cfg_t      cfg,
	input  wire dds_pkg::dp_cmd_t   cmd,
	output dds_pkg::dp_status_t     status,
	input  wire logic signed [15:0] in_linear,
	input  wire logic signed [15:0] in_angular,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      out_linear,
	output logic signed [15:0]      out_angular,
	output logic signed [31:0]      out_left,
	output logic signed [31:0]      out_right,
	output logic                    out_duty
);

	localparam int W  = VELOCITY_BITS;
	localparam int SW = W + 4;
	localparam int PW = SW + 26;
	localparam int CB = TICK_COUNTER_BITS;
	localparam int CW = (CB > 16) ? CB : 16;

	localparam logic signed [SW-1:0] VMAX = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] VMIN = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});
	localparam logic signed [PW-1:0] RND11 = PW'(1) << 11;
	localparam logic signed [PW-1:0] RND13 = PW'(1) << 13;
	localparam logic signed [PW-1:0] RND19 = PW'(1) << 19;
	localparam logic signed [PW-1:0] I32MAX = $signed({{(PW-31){1'b0}}, {31{1'b1}}});
	localparam logic signed [PW-1:0] I32MIN = $signed({{(PW-31){1'b1}}, {31{1'b0}}});

	function automatic logic signed [SW-1:0] sx16(input logic [15:0] v);
		return SW'($signed(v));
	endfunction

	function automatic logic signed [SW-1:0] sxw(input logic [W-1:0] v);
		return SW'($signed(v));
	endfunction

	// Lower bound first, then upper: inverted bounds give the upper one
	function automatic logic signed [SW-1:0] clamp_f(input logic signed [SW-1:0] x,
		input logic signed [SW-1:0] lo, input logic signed [SW-1:0] hi);
		logic signed [SW-1:0] y;
		y = x;
		if (y < lo) y = lo;
		if (y > hi) y = hi;
		return y;
	endfunction

	function automatic logic [W-1:0] sat_f(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] y;
		y = clamp_f(x, VMIN, VMAX);
		return y[W-1:0];
	endfunction

	function automatic logic [W-1:0] shape_f(input logic signed [SW-1:0] tgt,
		input logic [W-1:0] prev, input logic [63:0] lim, input logic accel,
		input logic vlim);
		logic signed [SW-1:0] t;
		logic signed [SW-1:0] p;
		logic signed [SW-1:0] d;
		t = tgt;
		p = sxw(prev);
		if (accel) begin
			d = clamp_f(t - p, sx16(lim[47:32]), sx16(lim[63:48]));
			t = p + d;
		end
		if (vlim) begin
			t = clamp_f(t, sx16(lim[15:0]), sx16(lim[31:16]));
		end
		return sat_f(t);
	endfunction

	function automatic logic signed [31:0] drive_f(input logic signed [PW-1:0] prod,
		input logic open_loop, input logic [14:0] max_duty);
		logic signed [PW-1:0] r;
		logic signed [PW-1:0] mx;
		mx = $signed({{(PW-15){1'b0}}, max_duty});
		if (open_loop) begin
			r = (prod + RND11) >>> 12;
			if (r < -mx) r = -mx;
			if (r > mx) r = mx;
		end else begin
			r = (prod + RND19) >>> 20;
			if (r < I32MIN) r = I32MIN;
			if (r > I32MAX) r = I32MAX;
		end
		return r[31:0];
	endfunction

	logic [W-1:0]  stored_lin_q;
	logic [W-1:0]  stored_ang_q;
	logic [W-1:0]  prev_lin_q;
	logic [W-1:0]  prev_ang_q;
	logic [CB-1:0] ticks_q;

	logic signed [SW-1:0] cmd_lin;
	logic signed [SW-1:0] cmd_ang;
	logic                 timed_out;
	logic [W-1:0]         shaped_lin;
	logic [W-1:0]         shaped_ang;
	logic                 open_loop;

	logic signed [SW-1:0] mul_a;
	logic signed [25:0]   mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] hw_full;
	logic signed [SW-1:0] hw_q;
	logic signed [31:0]   drive_now;
	logic signed [31:0]   left_q;
	logic signed [SW-1:0] out_lin_x;
	logic signed [SW-1:0] out_ang_x;

	logic                 out_valid_q;
	logic signed [15:0]   out_lin_q;
	logic signed [15:0]   out_ang_q;
	logic signed [31:0]   out_left_q;
	logic signed [31:0]   out_right_q;
	logic                 out_duty_q;

	assign open_loop = cfg.mode_flags[dds_pkg::MODE_OPEN_LOOP];

	// Command path: clamp where enabled, then saturate to the velocity width
	always_comb begin
		cmd_lin = sx16(in_linear);
		cmd_ang = sx16(in_angular);
		if (cfg.mode_flags[dds_pkg::MODE_LIN_VLIM]) begin
			cmd_lin = clamp_f(cmd_lin, sx16(cfg.linear_limits[15:0]),
				sx16(cfg.linear_limits[31:16]));
		end
		if (cfg.mode_flags[dds_pkg::MODE_ANG_VLIM]) begin
			cmd_ang = clamp_f(cmd_ang, sx16(cfg.angular_limits[15:0]),
				sx16(cfg.angular_limits[31:16]));
		end
	end

	// Tick path: counter already advanced when the tick was taken
	assign timed_out = CW'(ticks_q) > CW'(cfg.timeout_ticks);

	assign shaped_lin = shape_f(timed_out ? '0 : sxw(stored_lin_q), prev_lin_q,
		cfg.linear_limits, cfg.mode_flags[dds_pkg::MODE_LIN_ACCEL],
		cfg.mode_flags[dds_pkg::MODE_LIN_VLIM]);
	assign shaped_ang = shape_f(timed_out ? '0 : sxw(stored_ang_q), prev_ang_q,
		cfg.angular_limits, cfg.mode_flags[dds_pkg::MODE_ANG_ACCEL],
		cfg.mode_flags[dds_pkg::MODE_ANG_VLIM]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_lin_q <= '0;
			stored_ang_q <= '0;
			prev_lin_q   <= '0;
			prev_ang_q   <= '0;
			ticks_q      <= '0;
		end else begin
			if (cmd.store_cmd) begin
				stored_lin_q <= sat_f(cmd_lin);
				stored_ang_q <= sat_f(cmd_ang);
				ticks_q      <= '0;
			end else if (cmd.start_tick && (ticks_q != {CB{1'b1}})) begin
				ticks_q <= ticks_q + CB'(1);
			end
			if (cmd.shape) begin
				prev_lin_q <= shaped_lin;
				prev_ang_q <= shaped_ang;
			end
		end
	end

	// Shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			dds_pkg::MUL_HW:    mul_a = sxw(prev_ang_q);
			dds_pkg::MUL_LEFT:  mul_a = sxw(prev_lin_q) - hw_q;
			dds_pkg::MUL_RIGHT: mul_a = sxw(prev_lin_q) + hw_q;
			default:            mul_a = '0;
		endcase
		if (cmd.mul_sel == dds_pkg::MUL_HW) begin
			mul_b = $signed({10'd0, cfg.half_separation});
		end else if (open_loop) begin
			mul_b = $signed({10'd0, cfg.duty_gain});
		end else begin
			mul_b = $signed({2'd0, cfg.count_gain});
		end
	end

	assign mul_p     = mul_a * mul_b;
	assign hw_full   = (prod_q + RND13) >>> 14;
	assign drive_now = drive_f(prod_q, open_loop, cfg.max_duty);
	assign out_lin_x = sxw(prev_lin_q);
	assign out_ang_x = sxw(prev_ang_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.hw_load) begin
			hw_q <= hw_full[SW-1:0];
		end
		if (cmd.left_load) begin
			left_q <= drive_now;
		end
		if (cmd.out_load) begin
			out_lin_q   <= out_lin_x[15:0];
			out_ang_q   <= out_ang_x[15:0];
			out_left_q  <= left_q;
			out_right_q <= drive_now;
			out_duty_q  <= open_loop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_linear  = out_lin_q;
	assign out_angular = out_ang_q;
	assign out_left    = out_left_q;
	assign out_right   = out_right_q;
	assign out_duty    = out_duty_q;

endmodule

`default_nettype wire

// ===== hdl/diff_drive_command_shaper.sv =====
// Top level of the differential drive command shaper.
//
//  channel  | direction | tdata (low bit up)                           | tuser
//  ---------+-----------+----------------------------------------------+-----------------
//  s_       | in        | linear_command[15:0], angular_command[31:16] | operation
//  m_       | out       | shaped_linear, shaped_angular, left, right   | drive_is_duty
//  cfg_     | in        | index selects register, low data bits used   | -
//
// A command request returns no result. A tick request makes one shaping step and
// three passes through the single shared multiplier (half separation, left side,
// right side), each followed by a rounding step, before its result enters the
// output register; the next request is taken only after that.
// Reset clears the stored command, previous target and tick counter at once.
// A full output register holds the last step, and with it every request, until the
// waiting result is taken.
`default_nettype none

module diff_drive_command_shaper #(
	parameter int VELOCITY_BITS     = dds_pkg::VELOCITY_BITS_DEF,
	parameter int TICK_COUNTER_BITS = dds_pkg::TICK_COUNTER_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [31:0]                        s_tdata,  // linear_command, angular_command
	input  wire logic                               s_tuser,  // operation
	// Result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [95:0]                             m_tdata,  // shaped_linear, shaped_angular,
	                                                          // left_drive, right_drive
	output logic                                    m_tuser,  // drive_is_duty
	// Configuration writes
	input  wire logic                               cfg_we,
	input  wire logic [dds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [dds_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	dds_pkg::cfg_t       cfg;
	dds_pkg::dp_cmd_t    dp_cmd;
	dds_pkg::dp_status_t dp_status;

	logic signed [15:0] res_linear;
	logic signed [15:0] res_angular;
	logic signed [31:0] res_left;
	logic signed [31:0] res_right;

	// Register bank: the user must write it only while no request is in work; the bank does not enforce this
	dds_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Sequencer: takes a request only when idle
	dds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// Datapath: holds the shaper state and the result register
	dds_dp #(
		.VELOCITY_BITS     (VELOCITY_BITS),
		.TICK_COUNTER_BITS (TICK_COUNTER_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.in_linear   ($signed(s_tdata[15:0])),
		.in_angular  ($signed(s_tdata[31:16])),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_linear  (res_linear),
		.out_angular (res_angular),
		.out_left    (res_left),
		.out_right   (res_right),
		.out_duty    (m_tuser)
	);

	// Pack the result fields, lowest field first
	assign m_tdata = {res_right, res_left, res_angular, res_linear};

`ifndef SYNTHESIS
	// A tick holds off further requests while it is worked
	a_tick_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == dds_pkg::OP_TICK)) |=> !s_tready)
		else $error("request taken while a tick is in work");

	// A command request never produces a result
	a_command_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == dds_pkg::OP_COMMAND) && !m_tvalid)
		|=> !m_tvalid)
		else $error("result appeared after a command request");

	// A result is loaded only from the last tick step, never from idle
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result loaded while the sequencer was idle");
`endif

endmodule

`default_nettype wire

// ===== test/diff_drive_command_shaper_test.sv =====
// Self-checking bench for the drive command shaper: directed and random requests, scored per field.

module diff_drive_command_shaper_test;
	import dds_pkg::*;

	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 7;
	// A tick keeps the block busy after it is taken; give it margin before touching registers
	localparam int SETTLE_CYCLES    = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RUN_LIMIT        = 200_000 * 2 * HALF_PERIOD;

	localparam longint VELOCITY_MAX = (longint'(1) <<< (VELOCITY_BITS_DEF - 1)) - 1;
	localparam longint VELOCITY_MIN = -VELOCITY_MAX - 1;
	localparam longint DRIVE_MAX    = 64'sd2147483647;
	localparam longint DRIVE_MIN    = -DRIVE_MAX - 1;

	// One result as it appears on the result stream, fields in port order
	typedef struct packed {
		logic [15:0] shaped_linear;
		logic [15:0] shaped_angular;
		logic [31:0] left_drive;
		logic [31:0] right_drive;
		logic        drive_is_duty;
	} drive_result_t;

	typedef struct packed {
		logic        op;
		logic [15:0] linear;
		logic [15:0] angular;
	} request_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [31:0]              s_tdata   = '0;  // linear_command, angular_command
	logic                     s_tuser   = OP_COMMAND;  // operation
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [95:0]              m_tdata;   // shaped_linear, shaped_angular, left_drive, right_drive
	logic                     m_tuser;   // drive_is_duty
	logic                     cfg_we    = 1'b0;
	cfg_index_t               cfg_index = CFG_LINEAR_LIMITS;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	diff_drive_command_shaper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Shadow copy of the register file, updated after each write lands
	logic [63:0] lin_limits    = LINEAR_LIMITS_RST;
	logic [63:0] ang_limits    = ANGULAR_LIMITS_RST;
	logic [4:0]  mode          = MODE_FLAGS_RST;
	logic [15:0] half_sep      = HALF_SEPARATION_RST;
	logic [15:0] timeout_ticks = TIMEOUT_TICKS_RST;
	logic [15:0] duty_gain     = DUTY_GAIN_RST;
	logic [23:0] count_gain    = COUNT_GAIN_RST;
	logic [14:0] max_duty      = MAX_DUTY_RST;

	// Shadow of the shaper state: last command, last target, ticks since the command
	logic signed [VELOCITY_BITS_DEF-1:0] cmd_linear   = '0;
	logic signed [VELOCITY_BITS_DEF-1:0] cmd_angular  = '0;
	logic signed [VELOCITY_BITS_DEF-1:0] last_linear  = '0;
	logic signed [VELOCITY_BITS_DEF-1:0] last_angular = '0;
	logic [TICK_COUNTER_BITS_DEF-1:0]    idle_ticks   = '0;

	request_t      pending_requests[$];
	drive_result_t awaited_drives[$];
	request_t      next_request;
	int            offers_made    = 0;
	int            requests_taken = 0;
	int            failures       = 0;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	int            holds_asked    = 0;
	int            holds_served   = 0;
	int            hold_left      = 0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Signed Q4.12 field idx of a packed limits word
	function automatic longint limit_field(logic [63:0] word, int idx);
		logic signed [15:0] f;
		f = word[16*idx +: 16];
		return f;
	endfunction

	// Lower bound first, then upper: inverted bounds always give the upper one
	function automatic longint clamp(longint x, longint lo, longint hi);
		if (x < lo) x = lo;
		if (x > hi) x = hi;
		return x;
	endfunction

	function automatic longint round_half_up(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Step limit against the previous target, then velocity limit, then saturate
	function automatic longint limit_axis(longint target, longint prev, logic [63:0] lim,
			logic accel, logic vlim);
		if (accel)
			target = prev + clamp(target - prev, limit_field(lim, 2), limit_field(lim, 3));
		if (vlim)
			target = clamp(target, limit_field(lim, 0), limit_field(lim, 1));
		return clamp(target, VELOCITY_MIN, VELOCITY_MAX);
	endfunction

	// Side speed in Q.12 to duty (open loop) or encoder counts per second
	function automatic logic [31:0] wheel_drive(longint side);
		longint drive;
		if (mode[MODE_OPEN_LOOP]) begin
			drive = round_half_up(side * longint'(duty_gain), 12);
			drive = clamp(drive, -longint'(max_duty), longint'(max_duty));
		end else begin
			drive = clamp(round_half_up(side * longint'(count_gain), 20), DRIVE_MIN, DRIVE_MAX);
		end
		return drive[31:0];
	endfunction

	// Advance the shadow state by one accepted request; a tick queues its result
	task automatic take_request(logic op, logic [31:0] data);
		longint        v;
		longint        w;
		longint        hw;
		drive_result_t res;
		v = $signed(data[15:0]);
		w = $signed(data[31:16]);
		if (op == OP_COMMAND) begin
			if (mode[MODE_LIN_VLIM])
				v = clamp(v, limit_field(lin_limits, 0), limit_field(lin_limits, 1));
			if (mode[MODE_ANG_VLIM])
				w = clamp(w, limit_field(ang_limits, 0), limit_field(ang_limits, 1));
			cmd_linear  = VELOCITY_BITS_DEF'(clamp(v, VELOCITY_MIN, VELOCITY_MAX));
			cmd_angular = VELOCITY_BITS_DEF'(clamp(w, VELOCITY_MIN, VELOCITY_MAX));
			idle_ticks  = '0;
		end else begin
			if (idle_ticks != '1)
				idle_ticks++;
			v = cmd_linear;
			w = cmd_angular;
			// stale command: aim for standstill
			if (idle_ticks > timeout_ticks) begin
				v = 0;
				w = 0;
			end
			v = limit_axis(v, last_linear, lin_limits, mode[MODE_LIN_ACCEL], mode[MODE_LIN_VLIM]);
			w = limit_axis(w, last_angular, ang_limits, mode[MODE_ANG_ACCEL], mode[MODE_ANG_VLIM]);
			last_linear  = VELOCITY_BITS_DEF'(v);
			last_angular = VELOCITY_BITS_DEF'(w);
			hw = round_half_up(longint'(half_sep) * w, 14);
			res.shaped_linear  = v[15:0];
			res.shaped_angular = w[15:0];
			res.left_drive     = wheel_drive(v - hw);
			res.right_drive    = wheel_drive(v + hw);
			res.drive_is_duty  = mode[MODE_OPEN_LOOP];
			awaited_drives.push_back(res);
		end
	endtask

	function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s expected %h, got %h", $time, name, want, got);
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: scores both streams at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && s_tvalid && s_tready) begin
			take_request(s_tuser, s_tdata);
			requests_taken <= requests_taken + 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_drives.size() == 0) begin
				$display("%0t: result with none expected: %h user %b", $time, m_tdata, m_tuser);
				failures++;
			end else begin
				want = awaited_drives.pop_front();
				failures += field_mismatch("shaped_linear", 32'(want.shaped_linear),
					32'(m_tdata[15:0]));
				failures += field_mismatch("shaped_angular", 32'(want.shaped_angular),
					32'(m_tdata[31:16]));
				failures += field_mismatch("left_drive", want.left_drive, m_tdata[63:32]);
				failures += field_mismatch("right_drive", want.right_drive, m_tdata[95:64]);
				failures += field_mismatch("drive_is_duty", 32'(want.drive_is_duty),
					32'(m_tuser));
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: offers queued requests at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && offers_made != requests_taken)) begin
			// previous request taken (or none offered): advance or go idle
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_request = pending_requests.pop_front();
				s_tvalid    <= 1'b1;
				s_tuser     <= next_request.op;
				s_tdata     <= {next_request.angular, next_request.linear};
				offers_made <= offers_made + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold whenever one is asked for
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= LONG_HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_request(logic op, logic [15:0] linear, logic [15:0] angular);
		request_t r;
		r.op      = op;
		r.linear  = linear;
		r.angular = angular;
		pending_requests.push_back(r);
	endtask

	// Hold the stimulus until every queued request is taken and every result is back
	task automatic drain();
		while (pending_requests.size() != 0 || offers_made != requests_taken ||
				awaited_drives.size() != 0)
			@(posedge clk);
	endtask

	// Drain, then let a command or a last tick clear the block before a register write
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LINEAR_LIMITS:   lin_limits    = value;
			CFG_ANGULAR_LIMITS:  ang_limits    = value;
			CFG_MODE_FLAGS:      mode          = value[4:0];
			CFG_HALF_SEPARATION: half_sep      = value[15:0];
			CFG_TIMEOUT_TICKS:   timeout_ticks = value[15:0];
			CFG_DUTY_GAIN:       duty_gain     = value[15:0];
			CFG_COUNT_GAIN:      count_gain    = value[23:0];
			CFG_MAX_DUTY:        max_duty      = value[14:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [63:0] lin, logic [63:0] ang, logic [4:0] flags,
			logic [15:0] hs, logic [15:0] tmo, logic [15:0] dg, logic [23:0] cg,
			logic [14:0] md);
		write_register(CFG_LINEAR_LIMITS, lin);
		write_register(CFG_ANGULAR_LIMITS, ang);
		write_register(CFG_MODE_FLAGS, 64'(flags));
		write_register(CFG_HALF_SEPARATION, 64'(hs));
		write_register(CFG_TIMEOUT_TICKS, 64'(tmo));
		write_register(CFG_DUTY_GAIN, 64'(dg));
		write_register(CFG_COUNT_GAIN, 64'(cg));
		write_register(CFG_MAX_DUTY, 64'(md));
	endtask

	// Mostly sane limit sets (vmin at most vmax, down step at most zero), sometimes raw noise
	function automatic logic [63:0] random_limits();
		logic [15:0] vmin;
		logic [15:0] vmax;
		logic [15:0] down;
		logic [15:0] up;
		if ($urandom_range(3) == 0)
			return {$urandom, $urandom};
		vmin = 16'(-$urandom_range(16384));
		vmax = 16'($urandom_range(16384));
		down = 16'(-$urandom_range(2048));
		up   = 16'($urandom_range(2048));
		return {up, down, vmax, vmin};
	endfunction

	function automatic logic [15:0] random_velocity();
		case ($urandom_range(7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2, 3, 4: return 16'($urandom_range(8192) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_config();
		logic [14:0] md;
		case ($urandom_range(7))
			0:       md = '0;
			1:       md = 15'd25600;
			default: md = 15'($urandom_range(25600));
		endcase
		configure(random_limits(), random_limits(), 5'($urandom_range(31)), 16'($urandom),
			16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(12)),
			($urandom_range(3) == 0) ? 16'd0 : 16'($urandom), 24'($urandom), md);
	endtask

	// Roughly three ticks for two commands; tick payload is noise the block ignores
	task automatic random_requests(int count);
		repeat (count) begin
			if ($urandom_range(99) < 60)
				queue_request(OP_TICK, 16'($urandom), 16'($urandom));
			else
				queue_request(OP_COMMAND, random_velocity(), random_velocity());
		end
	endtask

	task automatic set_idling(int pattern);
		case (pattern)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// Reset settings: field extremes and alternating bit patterns, open loop
		queue_request(OP_TICK, 16'h0000, 16'h0000);
		queue_request(OP_COMMAND, 16'h7FFF, 16'h8000);
		queue_request(OP_TICK, 16'hFFFF, 16'hFFFF);
		queue_request(OP_COMMAND, 16'h8000, 16'h7FFF);
		queue_request(OP_TICK, 16'h0000, 16'h0000);
		queue_request(OP_COMMAND, 16'h5555, 16'hAAAA);
		queue_request(OP_TICK, 16'h5555, 16'hAAAA);
		queue_request(OP_COMMAND, 16'hAAAA, 16'h5555);
		queue_request(OP_TICK, 16'hAAAA, 16'h5555);
		queue_request(OP_COMMAND, 16'hFFFF, 16'h0001);
		queue_request(OP_TICK, 16'h0000, 16'h0000);
		settle();

		// Every limit on, closed loop, widest separation and gain; ramp up, then time out
		configure({16'h0200, 16'hFE00, 16'h2000, 16'hE000},
			{16'h0100, 16'hFF00, 16'h1000, 16'hF000}, 5'b11110, 16'hFFFF, 16'd3,
			DUTY_GAIN_RST, 24'hFFFFFF, MAX_DUTY_RST);
		queue_request(OP_COMMAND, 16'h7FFF, 16'h8000);
		repeat (6) queue_request(OP_TICK, 16'h0000, 16'h0000);
		settle();

		// Inverted step bounds drive the linear target into saturation; inverted angular
		// velocity bounds pin it to the upper one
		configure({16'h7D00, 16'h7FFF, 16'h0000, 16'h0000},
			{16'h0000, 16'h0000, 16'hF000, 16'h1000}, 5'b01101, 16'h4000, 16'hFFFF,
			16'hFFFF, COUNT_GAIN_RST, 15'd25600);
		queue_request(OP_COMMAND, 16'h0100, 16'h1234);
		repeat (3) queue_request(OP_TICK, 16'h0000, 16'h0000);
		settle();

		// Zero duty gain and zero separation, with a one-tick timeout
		configure('0, '0, 5'b00001, 16'd0, 16'd1, 16'd0, 24'd0, 15'd25600);
		queue_request(OP_COMMAND, 16'h1000, 16'h1000);
		repeat (2) queue_request(OP_TICK, 16'h0000, 16'h0000);
		settle();

		// Zero duty clamp
		configure('0, '0, 5'b00001, HALF_SEPARATION_RST, TIMEOUT_TICKS_RST, DUTY_GAIN_RST,
			COUNT_GAIN_RST, 15'd0);
		queue_request(OP_COMMAND, 16'h7FFF, 16'h8000);
		queue_request(OP_TICK, 16'h0000, 16'h0000);
		settle();

		// Random blocks, each with fresh settings and its own idling pattern
		for (int blk = 0; blk < 8; blk++) begin
			random_config();
			set_idling(blk % 4);
			if (blk == 0) begin
				// stall the output while the sender keeps offering, so the input backs up
				holds_asked++;
				random_requests(75);
			end else if (blk == 5) begin
				// pause the sender mid-block until every result is back
				random_requests(37);
				drain();
				random_requests(38);
			end else begin
				random_requests(75);
			end
			settle();
		end

		if (failures == 0 && awaited_drives.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
